[sv/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted.
`define CVRL_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// A condition that must never be true at a clock edge.
`define CVRL_NEVER(lbl, cond, msg) \
	`CVRL_ASSERT(lbl, !(cond), msg)

`endif

[sv/cvrl_pkg.sv]
`timescale 1ns / 1ps
package cvrl_pkg;

	localparam int RATE_W     = 24;
	localparam int DT_W       = 16;
	localparam int CFG_DATA_W = 24;
	localparam int CFG_IDX_W  = 3;

	localparam logic [CFG_IDX_W-1:0] REG_MAX_INTERVAL = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LIN_ACCEL    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LIN_BRAKE    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LIN_STOP     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_YAW_ACCEL    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_YAW_BRAKE    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_YAW_STOP     = 3'd6;

	typedef enum logic [7:0] {
		ST_IDLE   = 8'b0000_0001,
		ST_MUL    = 8'b0000_0010,
		ST_SUM    = 8'b0000_0100,
		ST_SQRT   = 8'b0000_1000,
		ST_DECIDE = 8'b0001_0000,
		ST_DIVX   = 8'b0010_0000,
		ST_DIVY   = 8'b0100_0000,
		ST_FIN    = 8'b1000_0000
	} state_t;

endpackage

[sv/chassis_velocity_ramp_limiter.sv]
// A clear passes through the FIN state to the output register; a ramp step runs through
// MUL, SUM, SQRT and DECIDE, and through DIVX and DIVY when the planar step is divided out.
// Transactions never overlap: a new one is taken only in IDLE; the shared multiplier,
// the square-root and division shift-subtract logic and their sequencer serve one at a time.
// Reset (arst_n low, asynchronous) clears velocities, config registers and the output valid.
`timescale 1ns / 1ps
module chassis_velocity_ramp_limiter #(
	parameter int VEL_WIDTH = 24
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	// target_x, target_y, target_yaw, interval (lowest bits first), zero padded
	input  logic [((3*VEL_WIDTH+cvrl_pkg::DT_W+7)/8)*8-1:0] s_tdata,
	// func
	input  logic s_tuser,
	output logic m_tvalid,
	input  logic m_tready,
	// vel_x, vel_y, vel_yaw (lowest bits first), zero padded
	output logic [((3*VEL_WIDTH+7)/8)*8-1:0] m_tdata,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [cvrl_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [cvrl_pkg::CFG_DATA_W-1:0] cfg_data
);
	import cvrl_pkg::*;

	localparam int VW     = VEL_WIDTH;
	localparam int DW     = VW + 1;
	localparam int MW     = (DW > RATE_W) ? DW : RATE_W;
	localparam int PW     = 2 * MW;
	localparam int RW     = DW;
	localparam int SW     = 2 * RW;
	localparam int CW     = $clog2(RW + 1);
	localparam int OUT_TW = ((3 * VW + 7) / 8) * 8;

	state_t state_q;
	logic [CW-1:0] cnt_q;

	logic [DT_W-1:0] max_int_q;
	logic [RATE_W-1:0] lin_acc_q, lin_brk_q, lin_stp_q, yaw_acc_q, yaw_brk_q, yaw_stp_q;
	logic signed [VW-1:0] vel_x_q, vel_y_q, vel_w_q;
	logic [VW-1:0] out_x_q, out_y_q, out_w_q;
	logic m_tvalid_q;

	logic signed [VW-1:0] tx_q, ty_q, tw_q;
	logic [DT_W-1:0] dt_q;
	logic signed [DW-1:0] dx_q, dy_q, dw_q;
	logic [DW-1:0] ax_q, ay_q, aw_q;
	logic [PW-1:0] sqx_q, sqy_q, px_q, py_q, nx_q, ny_q;
	logic [RATE_W-1:0] lstep_q, wstep_q;
	logic [SW-1:0] op_q, res_q, one_q;
	logic [RW:0] rem_q;
	logic [DW-1:0] lo_q;

	// Input unpacking and differences against the present state.
	logic signed [VW-1:0] in_tx, in_ty, in_tw;
	logic [DT_W-1:0] in_dt, dt_clamp;
	logic signed [DW-1:0] in_dx, in_dy, in_dw;
	logic [DW-1:0] in_ax, in_ay, in_aw;
	logic s_acc;

	assign in_tx    = s_tdata[VW-1:0];
	assign in_ty    = s_tdata[2*VW-1:VW];
	assign in_tw    = s_tdata[3*VW-1:2*VW];
	assign in_dt    = s_tdata[3*VW +: DT_W];
	assign dt_clamp = (max_int_q != '0 && in_dt > max_int_q) ? max_int_q : in_dt;
	assign in_dx    = DW'(in_tx) - DW'(vel_x_q);
	assign in_dy    = DW'(in_ty) - DW'(vel_y_q);
	assign in_dw    = DW'(in_tw) - DW'(vel_w_q);
	assign in_ax    = in_dx[DW-1] ? DW'(-in_dx) : DW'(in_dx);
	assign in_ay    = in_dy[DW-1] ? DW'(-in_dy) : DW'(in_dy);
	assign in_aw    = in_dw[DW-1] ? DW'(-in_dw) : DW'(in_dw);
	assign s_tready = (state_q == ST_IDLE);
	assign s_acc    = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;

	// Rate selection.
	logic [VW-1:0] vxa, vya;
	logic n1, n2, lin_neg;
	logic [RATE_W-1:0] lin_rate, yaw_rate;

	assign vxa = vel_x_q[VW-1] ? VW'(-vel_x_q) : VW'(vel_x_q);
	assign vya = vel_y_q[VW-1] ? VW'(-vel_y_q) : VW'(vel_y_q);
	assign n1  = (vel_x_q != '0) && (vel_x_q[VW-1] != dx_q[DW-1]);
	assign n2  = (vel_y_q != '0) && (vel_y_q[VW-1] != dy_q[DW-1]);

	always_comb begin
		if (n1 == n2) begin
			lin_neg = n1;
		end else if (n1) begin
			lin_neg = (px_q > py_q);
		end else begin
			lin_neg = (py_q > px_q);
		end
		if (tx_q == '0 && ty_q == '0) begin
			lin_rate = lin_stp_q;
		end else begin
			lin_rate = lin_neg ? lin_brk_q : lin_acc_q;
		end
		if (tw_q == '0) begin
			yaw_rate = yaw_stp_q;
		end else if (vel_w_q != '0 && vel_w_q[VW-1] != dw_q[DW-1]) begin
			yaw_rate = yaw_brk_q;
		end else begin
			yaw_rate = yaw_acc_q;
		end
	end

	// Shared multiplier, one product per cycle in the multiply phase.
	logic [MW-1:0] mul_a, mul_b;
	logic [PW-1:0] prod;

	always_comb begin
		unique case (cnt_q)
			CW'(0): begin
				mul_a = MW'(ax_q);
				mul_b = MW'(ax_q);
			end
			CW'(1): begin
				mul_a = MW'(ay_q);
				mul_b = MW'(ay_q);
			end
			CW'(2): begin
				mul_a = MW'(vxa);
				mul_b = MW'(ax_q);
			end
			CW'(3): begin
				mul_a = MW'(vya);
				mul_b = MW'(ay_q);
			end
			CW'(4): begin
				mul_a = MW'(lin_rate);
				mul_b = MW'(dt_q);
			end
			CW'(5): begin
				mul_a = MW'(yaw_rate);
				mul_b = MW'(dt_q);
			end
			CW'(6): begin
				mul_a = MW'(ax_q);
				mul_b = MW'(lstep_q);
			end
			CW'(7): begin
				mul_a = MW'(ay_q);
				mul_b = MW'(lstep_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod = PW'(mul_a) * PW'(mul_b);

	// Subtract logic: one square-root digit or one quotient bit per cycle.
	logic [SW-1:0] sq_try;
	logic sq_ge;
	logic [RW-1:0] root;
	logic [RW:0] div_t;
	logic div_ge;
	logic [DW-1:0] quot;

	assign sq_try = res_q + one_q;
	assign sq_ge  = (op_q >= sq_try);
	assign root   = res_q[RW-1:0];
	assign div_t  = {rem_q[RW-1:0], lo_q[DW-1]};
	assign div_ge = (div_t >= {1'b0, root});
	assign quot   = {lo_q[DW-2:0], div_ge};

	// Decision terms.
	logic lin_skip, lin_jump, yaw_skip, yaw_jump, div_last, len_short, div_first;
	logic [VW-1:0] yaw_next, x_next, y_next;

	assign len_short = (MW'(root) <= MW'(lstep_q));
	assign lin_skip = (dx_q == '0 && dy_q == '0) || dt_q == '0;
	assign lin_jump = (lin_rate == '0) || len_short;
	assign yaw_skip = (dw_q == '0) || dt_q == '0;
	assign yaw_jump = (yaw_rate == '0) || (MW'(aw_q) <= MW'(wstep_q));
	assign yaw_next = dw_q[DW-1] ? VW'(MW'(vel_w_q) - MW'(wstep_q))
	                             : VW'(MW'(vel_w_q) + MW'(wstep_q));
	assign x_next   = dx_q[DW-1] ? VW'(MW'(vel_x_q) - MW'(quot))
	                             : VW'(MW'(vel_x_q) + MW'(quot));
	assign y_next   = dy_q[DW-1] ? VW'(MW'(vel_y_q) - MW'(quot))
	                             : VW'(MW'(vel_y_q) + MW'(quot));
	assign div_last = (cnt_q == CW'(DW - 1));
	assign div_first = (state_q == ST_DIVX) && (cnt_q == '0);

	logic out_load;
	assign out_load = (state_q == ST_FIN) && (!m_tvalid_q || m_tready);

	// Control, configuration and velocity state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			cnt_q      <= '0;
			max_int_q  <= '0;
			lin_acc_q  <= '0;
			lin_brk_q  <= '0;
			lin_stp_q  <= '0;
			yaw_acc_q  <= '0;
			yaw_brk_q  <= '0;
			yaw_stp_q  <= '0;
			vel_x_q    <= '0;
			vel_y_q    <= '0;
			vel_w_q    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					REG_MAX_INTERVAL: max_int_q <= cfg_data[DT_W-1:0];
					REG_LIN_ACCEL:    lin_acc_q <= cfg_data;
					REG_LIN_BRAKE:    lin_brk_q <= cfg_data;
					REG_LIN_STOP:     lin_stp_q <= cfg_data;
					REG_YAW_ACCEL:    yaw_acc_q <= cfg_data;
					REG_YAW_BRAKE:    yaw_brk_q <= cfg_data;
					REG_YAW_STOP:     yaw_stp_q <= cfg_data;
					default: ;
				endcase
			end
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					cnt_q <= '0;
					if (s_acc) begin
						if (s_tuser) begin
							vel_x_q <= '0;
							vel_y_q <= '0;
							vel_w_q <= '0;
							state_q <= ST_FIN;
						end else begin
							state_q <= ST_MUL;
						end
					end
				end
				ST_MUL: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CW'(7)) begin
						state_q <= ST_SUM;
					end
				end
				ST_SUM: begin
					cnt_q   <= '0;
					state_q <= ST_SQRT;
				end
				ST_SQRT: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CW'(RW - 1)) begin
						state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					cnt_q <= '0;
					if (!yaw_skip) begin
						vel_w_q <= yaw_jump ? tw_q : yaw_next;
					end
					if (lin_skip) begin
						state_q <= ST_FIN;
					end else if (lin_jump) begin
						vel_x_q <= tx_q;
						vel_y_q <= ty_q;
						state_q <= ST_FIN;
					end else begin
						state_q <= ST_DIVX;
					end
				end
				ST_DIVX: begin
					if (div_last) begin
						vel_x_q <= x_next;
						cnt_q   <= '0;
						state_q <= ST_DIVY;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_DIVY: begin
					cnt_q <= cnt_q + 1'b1;
					if (div_last) begin
						vel_y_q <= y_next;
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (s_acc) begin
			tx_q <= in_tx;
			ty_q <= in_ty;
			tw_q <= in_tw;
			dt_q <= dt_clamp;
			dx_q <= in_dx;
			dy_q <= in_dy;
			dw_q <= in_dw;
			ax_q <= in_ax;
			ay_q <= in_ay;
			aw_q <= in_aw;
		end
		if (state_q == ST_MUL) begin
			unique case (cnt_q)
				CW'(0): sqx_q <= prod;
				CW'(1): sqy_q <= prod;
				CW'(2): px_q <= prod;
				CW'(3): py_q <= prod;
				CW'(4): lstep_q <= prod[DT_W +: RATE_W];
				CW'(5): wstep_q <= prod[DT_W +: RATE_W];
				CW'(6): nx_q <= prod;
				CW'(7): ny_q <= prod;
				default: ;
			endcase
		end
		if (state_q == ST_SUM) begin
			op_q  <= sqx_q[SW-1:0] + sqy_q[SW-1:0];
			res_q <= '0;
			one_q <= SW'(1) << (SW - 2);
		end
		if (state_q == ST_SQRT) begin
			if (sq_ge) begin
				op_q  <= op_q - sq_try;
				res_q <= (res_q >> 1) + one_q;
			end else begin
				res_q <= res_q >> 1;
			end
			one_q <= one_q >> 2;
		end
		// The quotient is known to be below 2^DW, so the high part of the
		// numerator already lies below the divisor.
		if (state_q == ST_DECIDE) begin
			rem_q <= {1'b0, nx_q[DW +: RW]};
			lo_q  <= nx_q[DW-1:0];
		end
		if (state_q == ST_DIVX && div_last) begin
			rem_q <= {1'b0, ny_q[DW +: RW]};
			lo_q  <= ny_q[DW-1:0];
		end else if (state_q == ST_DIVX || state_q == ST_DIVY) begin
			rem_q <= div_ge ? (div_t - {1'b0, root}) : div_t;
			lo_q  <= quot;
		end
		if (out_load) begin
			out_x_q <= vel_x_q;
			out_y_q <= vel_y_q;
			out_w_q <= vel_w_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = OUT_TW'({out_w_q, out_y_q, out_x_q});

	`include "assert_macros.svh"

	`CVRL_ASSERT(a_busy_after_accept, s_acc |=> !s_tready, "accepted while busy")
	`CVRL_ASSERT(a_load_from_fin, $rose(m_tvalid) |-> $past(state_q == ST_FIN), "early result")
	`CVRL_NEVER(a_div_needs_long, div_first && len_short, "division entered with short length")

endmodule

[bench/chassis_velocity_ramp_limiter_test.sv]
`timescale 1ns / 1ps
module chassis_velocity_ramp_limiter_test;
	import cvrl_pkg::*;

	localparam int VW = 24;
	localparam longint VMAX = 64'sd8388607;
	localparam longint VMIN = -64'sd8388608;
	localparam int SETTLE = 100;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int RANDOM_PHASES = 8;
	localparam int PHASE_ITEMS = 135;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

	typedef struct {
		bit           clear;
		longint       tx;
		longint       ty;
		longint       tw;
		bit [DT_W-1:0] dt;
	} target_t;

	typedef struct {
		logic [VW-1:0] vx;
		logic [VW-1:0] vy;
		logic [VW-1:0] vw;
	} vel_t;

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [87:0] s_tdata;
	logic s_tuser;
	logic m_tvalid;
	logic m_tready;
	logic [71:0] m_tdata;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	chassis_velocity_ramp_limiter #(.VEL_WIDTH(VW)) dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	target_t target_queue[$];
	vel_t vel_expected[$];
	target_t on_bus;
	bit taken;
	bit quiet;
	int errors;
	int cycles;
	int src_gap;
	int sink_stall;

	// Predictor state and register copy.
	longint cur_x, cur_y, cur_w;
	longint unsigned max_dt;
	longint unsigned lin_acc, lin_brk, lin_stp, yaw_acc, yaw_brk, yaw_stp;

	function automatic longint unsigned magnitude(longint v);
		return v < 0 ? longint'(-v) : longint'(v);
	endfunction

	function automatic longint unsigned root_floor(logic [127:0] s);
		longint unsigned r, c;
		logic [127:0] cc;
		r = 0;
		for (int b = 40; b >= 0; b--) begin
			c = r | (64'd1 << b);
			cc = {64'd0, c} * {64'd0, c};
			if (cc <= s)
				r = c;
		end
		return r;
	endfunction

	function automatic void planar_step(longint tx, longint ty, longint unsigned dt);
		longint dx, dy;
		longint unsigned len, rate, step, ph, qh, qx, qy;
		logic [127:0] sum;
		bit n1, n2, neg;
		dx = tx - cur_x;
		dy = ty - cur_y;
		if ((dx == 0 && dy == 0) || dt == 0)
			return;
		sum = {64'd0, magnitude(dx) * magnitude(dx)} + {64'd0, magnitude(dy) * magnitude(dy)};
		len = root_floor(sum);
		if (tx == 0 && ty == 0) begin
			rate = lin_stp;
		end else begin
			ph = magnitude(cur_x) * magnitude(dx);
			qh = magnitude(cur_y) * magnitude(dy);
			n1 = cur_x != 0 && ((cur_x < 0) != (dx < 0));
			n2 = cur_y != 0 && ((cur_y < 0) != (dy < 0));
			// Only the opposing component's share of the dot product can make it negative.
			if (n1 == n2)
				neg = n1;
			else if (n1)
				neg = !(ph <= qh);
			else
				neg = !(qh <= ph);
			rate = neg ? lin_brk : lin_acc;
		end
		step = (rate * dt) >> 16;
		if (rate == 0 || len <= step) begin
			cur_x = tx;
			cur_y = ty;
			return;
		end
		qx = (magnitude(dx) * step) / len;
		qy = (magnitude(dy) * step) / len;
		cur_x = dx < 0 ? cur_x - longint'(qx) : cur_x + longint'(qx);
		cur_y = dy < 0 ? cur_y - longint'(qy) : cur_y + longint'(qy);
	endfunction

	function automatic void yaw_step(longint tw, longint unsigned dt);
		longint d;
		longint unsigned rate, step;
		d = tw - cur_w;
		if (d == 0 || dt == 0)
			return;
		if (tw == 0)
			rate = yaw_stp;
		else if (cur_w != 0 && ((cur_w < 0) != (d < 0)))
			rate = yaw_brk;
		else
			rate = yaw_acc;
		step = (rate * dt) >> 16;
		if (rate == 0 || magnitude(d) <= step)
			cur_w = tw;
		else
			cur_w = d > 0 ? cur_w + longint'(step) : cur_w - longint'(step);
	endfunction

	function automatic vel_t ramp_predict(target_t t);
		vel_t v;
		longint unsigned dt;
		if (t.clear) begin
			cur_x = 0;
			cur_y = 0;
			cur_w = 0;
		end else begin
			dt = t.dt;
			if (max_dt != 0 && dt > max_dt)
				dt = max_dt;
			planar_step(t.tx, t.ty, dt);
			yaw_step(t.tw, dt);
		end
		v.vx = cur_x[VW-1:0];
		v.vy = cur_y[VW-1:0];
		v.vw = cur_w[VW-1:0];
		return v;
	endfunction

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, longint unsigned value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value[CFG_DATA_W-1:0];
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			REG_MAX_INTERVAL: max_dt = value & 64'hFFFF;
			REG_LIN_ACCEL:    lin_acc = value & 64'hFFFFFF;
			REG_LIN_BRAKE:    lin_brk = value & 64'hFFFFFF;
			REG_LIN_STOP:     lin_stp = value & 64'hFFFFFF;
			REG_YAW_ACCEL:    yaw_acc = value & 64'hFFFFFF;
			REG_YAW_BRAKE:    yaw_brk = value & 64'hFFFFFF;
			REG_YAW_STOP:     yaw_stp = value & 64'hFFFFFF;
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic write_all(longint unsigned mi, longint unsigned la, longint unsigned lb,
			longint unsigned ls, longint unsigned ya, longint unsigned yb, longint unsigned ys);
		write_reg(REG_MAX_INTERVAL, mi);
		write_reg(REG_LIN_ACCEL, la);
		write_reg(REG_LIN_BRAKE, lb);
		write_reg(REG_LIN_STOP, ls);
		write_reg(REG_YAW_ACCEL, ya);
		write_reg(REG_YAW_BRAKE, yb);
		write_reg(REG_YAW_STOP, ys);
	endtask

	task automatic drain();
		@(posedge clk);
		while (target_queue.size() != 0 || s_tvalid || vel_expected.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	function automatic target_t item(bit c, longint x, longint y, longint w, int dt);
		target_t t;
		t.clear = c;
		t.tx = x;
		t.ty = y;
		t.tw = w;
		t.dt = dt[DT_W-1:0];
		return t;
	endfunction

	function automatic longint rand_vel();
		logic [VW-1:0] raw;
		case ($urandom_range(0, 9))
			0: return 0;
			1: return $urandom_range(0, 1) ? VMAX : VMIN;
			2, 3, 4: return longint'($urandom_range(0, 1 << 19)) - (1 << 18);
			default: begin
				raw = VW'($urandom);
				return longint'($signed(raw));
			end
		endcase
	endfunction

	function automatic int rand_dt();
		case ($urandom_range(0, 19))
			0, 1: return 0;
			2: return 65535;
			3, 4, 5: return $urandom_range(0, 65535);
			default: return $urandom_range(1, 2000);
		endcase
	endfunction

	function automatic longint unsigned rand_rate();
		case ($urandom_range(0, 19))
			0, 1, 2: return 0;
			3, 4: return 24'hFFFFFF;
			5: return $urandom_range(1, 255);
			default: return $urandom_range(1 << 12, 1 << 22);
		endcase
	endfunction

	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// Source side: the expectation is computed the moment a transaction is accepted.
	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready) begin
			vel_expected.push_back(ramp_predict(on_bus));
			taken = 1'b1;
		end
	end

	always @(negedge clk) begin
		if (arst_n && (!s_tvalid || taken)) begin
			taken = 1'b0;
			if (src_gap > 0) begin
				src_gap--;
				s_tvalid <= 1'b0;
			end else if (target_queue.size() != 0 && !quiet && $urandom_range(0, 5) == 0) begin
				src_gap = $urandom_range(0, 3);
				s_tvalid <= 1'b0;
			end else if (target_queue.size() != 0) begin
				on_bus = target_queue.pop_front();
				s_tvalid <= 1'b1;
				s_tuser <= on_bus.clear;
				s_tdata <= {on_bus.dt, on_bus.tw[VW-1:0], on_bus.ty[VW-1:0], on_bus.tx[VW-1:0]};
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if (sink_stall > 0) begin
				sink_stall--;
				m_tready <= 1'b0;
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				sink_stall = $urandom_range(0, 3);
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		vel_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (vel_expected.size() == 0) begin
				$error("unexpected result transaction %h", m_tdata);
				errors++;
			end else begin
				want = vel_expected.pop_front();
				if (m_tdata[23:0] !== want.vx) begin
					$error("vel_x expected %h actual %h", want.vx, m_tdata[23:0]);
					errors++;
				end
				if (m_tdata[47:24] !== want.vy) begin
					$error("vel_y expected %h actual %h", want.vy, m_tdata[47:24]);
					errors++;
				end
				if (m_tdata[71:48] !== want.vw) begin
					$error("vel_yaw expected %h actual %h", want.vw, m_tdata[71:48]);
					errors++;
				end
			end
		end
	end

	initial begin
		target_t last;
		int left;
		clk = 1'b0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = 1'b0;
		m_tready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		errors = 0;
		cycles = 0;
		src_gap = 0;
		sink_stall = 0;
		taken = 1'b0;
		quiet = 1'b0;
		cur_x = 0;
		cur_y = 0;
		cur_w = 0;
		max_dt = 0;
		lin_acc = 0;
		lin_brk = 0;
		lin_stp = 0;
		yaw_acc = 0;
		yaw_brk = 0;
		yaw_stp = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// All rates still zero after reset, so targets are taken directly.
		target_queue.push_back(item(0, 1000, -2000, 3000, 100));
		target_queue.push_back(item(0, 1000, -2000, 3000, 500));
		target_queue.push_back(item(0, VMAX, VMIN, VMAX, 1));
		drain();
		write_reg(REG_UNUSED, 24'h123456);
		write_all(4096, 1 << 16, 2 << 16, 3 << 16, 1 << 16, 2 << 16, 3 << 16);
		target_queue.push_back(item(1, 5, 5, 5, 5));
		target_queue.push_back(item(0, VMAX, 0, VMAX, 1000));
		target_queue.push_back(item(0, VMAX, 0, VMAX, 65535));
		target_queue.push_back(item(0, VMIN, VMIN, VMIN, 0));
		target_queue.push_back(item(0, VMIN, VMIN, VMIN, 3000));
		target_queue.push_back(item(0, 0, 0, 0, 2000));
		target_queue.push_back(item(0, -1000, VMAX, -1000, 4000));
		target_queue.push_back(item(0, 1 << 17, -(1 << 16), 7, 65535));
		target_queue.push_back(item(0, VMAX, VMAX, VMAX, 65535));
		target_queue.push_back(item(0, 0, 0, 0, 0));
		target_queue.push_back(item(1, VMAX, VMIN, 0, 65535));
		drain();
		write_all(0, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
		target_queue.push_back(item(0, VMIN, VMAX, VMIN, 65535));
		target_queue.push_back(item(0, 3, -4, 1, 1));
		target_queue.push_back(item(0, 3, -4, 1, 1));
		target_queue.push_back(item(0, 0, 0, 0, 65535));
		drain();

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			case (p)
				0: write_all(65535, 1, 1, 1, 1, 1, 1);
				1: write_all(0, 0, 0, 0, 0, 0, 0);
				default: write_all($urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 65535),
					rand_rate(), rand_rate(), rand_rate(), rand_rate(), rand_rate(), rand_rate());
			endcase
			last = item(0, 0, 0, 0, 0);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				left = (RANDOM_PHASES - p - 1) * PHASE_ITEMS + (PHASE_ITEMS - i);
				quiet = left < 120;
				// Holding a target for a while lets the ramp converge onto it.
				if ($urandom_range(0, 2) != 0 && i != 0) begin
					last.dt = DT_W'(rand_dt());
					last.clear = 1'b0;
				end else begin
					last = item($urandom_range(0, 29) == 0, rand_vel(), rand_vel(), rand_vel(),
						rand_dt());
				end
				target_queue.push_back(last);
			end
			drain();
		end

		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end
endmodule

[chassis_velocity_ramp_limiter.f]
+incdir+sv
sv/cvrl_pkg.sv
sv/chassis_velocity_ramp_limiter.sv
bench/chassis_velocity_ramp_limiter_test.sv
